[sv/dfs_path_finder_core_defines.svh]
// ----------------------------------------------------------------------------
// dfs path finder assertion macros
// shared property forms for the path finder checks
// ----------------------------------------------------------------------------
`ifndef DFS_PATH_FINDER_CORE_DEFINES_SVH
`define DFS_PATH_FINDER_CORE_DEFINES_SVH

// same-cycle implication
`define DFS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/dfs_pkg.sv]
// ----------------------------------------------------------------------------
// dfs path finder package
// field widths, command and status codes
// ----------------------------------------------------------------------------
package dfs_pkg;

    localparam int VW          = 6;
    localparam int CFG_W       = 7;
    localparam int FIELD_LIMIT = 64;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_FIND  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOPATH = 2'd1,
        ST_FULL   = 2'd2,
        ST_RANGE  = 2'd3
    } status_t;

endpackage

[sv/dfs_path_finder_core.sv]
// add edge: dispatch, degree reads, a and b entry writes (none when a list is full), result register
// clear, unused command or out-of-range item: dispatch, then the result register
// search: each neighbor tried is read from the neighbor ram, a pop restores from the stack ram
// a path then streams vertex by vertex from the stack ram
// not ready while an item is in progress; one item at a time
// reset empties the graph at once (degree valid bits), vertex_count becomes 64
// ----------------------------------------------------------------------------
// dfs path finder core
// undirected graph store with depth-first path search on an explicit stack
// ----------------------------------------------------------------------------
`include "dfs_path_finder_core_defines.svh"

module dfs_path_finder_core
    import dfs_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_DEGREE   = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       cmd,
    input  logic [VW-1:0]    vertex_a,
    input  logic [VW-1:0]    vertex_b,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [VW-1:0]    vertex,
    output logic [1:0]       status,
    output logic             last
);

    localparam int NV     = (MAX_VERTICES < FIELD_LIMIT) ? MAX_VERTICES : FIELD_LIMIT;
    localparam int VIW    = $clog2(NV);
    localparam int DW     = $clog2(MAX_DEGREE + 1);
    localparam int NDEPTH = NV * MAX_DEGREE;
    localparam int NAW    = $clog2(NDEPTH);
    localparam int SAW    = $clog2(NV);
    localparam int SDW    = $clog2(NV + 1);
    localparam int SEW    = VIW + DW;

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_EDGE_RA, S_EDGE_RB, S_EDGE_WB, S_ONE,
        S_TOP, S_CHK, S_POP, S_PATH, S_PRD, S_PEMIT
    } state_t;

    state_t           state_reg;
    cmd_t             cmd_reg;
    logic [VW-1:0]    a_reg, b_reg;
    logic [CFG_W-1:0] vertex_count_reg;
    logic [DW-1:0]    deg_a_reg, deg_b_reg;
    logic [VIW-1:0]   top_v_reg;
    logic [DW-1:0]    top_p_reg;
    logic [SDW-1:0]   depth_reg;
    logic [SAW-1:0]   idx_reg;
    logic [NV-1:0]    visited_reg, deg_valid_reg;
    logic             dv_reg;
    logic [VW-1:0]    res_vertex_reg;
    status_t          res_status_reg;
    logic             out_valid_reg, last_reg;
    logic [VW-1:0]    vertex_reg;
    status_t          status_reg;

    logic [CFG_W-1:0] lim;
    logic             a_ok, b_ok, out_free, out_load;
    logic [DW-1:0]    deg_eff, deg_b_eff;
    logic             edge_full, skip;
    logic [VW-1:0]    nb;

    logic             deg_we;
    logic [VIW-1:0]   deg_waddr, deg_raddr;
    logic [DW-1:0]    deg_wdata, deg_rdata;
    logic             nbr_we;
    logic [NAW-1:0]   nbr_waddr, nbr_raddr;
    logic [VW-1:0]    nbr_wdata, nbr_rdata;
    logic             stk_we;
    logic [SAW-1:0]   stk_waddr, stk_raddr;
    logic [SEW-1:0]   stk_wdata, stk_rdata;

    function automatic logic [NAW-1:0] nbr_addr(input logic [VIW-1:0] v,
                                                 input logic [DW-1:0] p);
        int sum;
        sum = int'(v) * MAX_DEGREE + int'(p);
        return NAW'(sum);
    endfunction

    assign lim      = (vertex_count_reg > CFG_W'(NV)) ? CFG_W'(NV) : vertex_count_reg;
    assign a_ok     = {1'b0, a_reg} < lim;
    assign b_ok     = {1'b0, b_reg} < lim;
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = out_free && ((state_reg == S_ONE) || (state_reg == S_PATH)
                                   || (state_reg == S_PEMIT));
    assign deg_eff  = dv_reg ? deg_rdata : '0;
    assign deg_b_eff = (a_reg == b_reg) ? DW'(int'(deg_a_reg) + 1) : deg_eff;
    assign edge_full = (a_reg == b_reg) ? (int'(deg_a_reg) + 2 > MAX_DEGREE)
                     : ((int'(deg_a_reg) >= MAX_DEGREE) || (int'(deg_eff) >= MAX_DEGREE));
    assign nb       = nbr_rdata;
    assign skip     = (nb == VW'(top_v_reg)) || !({1'b0, nb} < lim)
                    || visited_reg[nb[VIW-1:0]];

    always_comb
    begin
        deg_we    = 1'b0;
        deg_waddr = a_reg[VIW-1:0];
        deg_wdata = DW'(int'(deg_a_reg) + 1);
        deg_raddr = top_v_reg;
        nbr_we    = 1'b0;
        nbr_waddr = nbr_addr(a_reg[VIW-1:0], deg_a_reg);
        nbr_wdata = b_reg;
        nbr_raddr = nbr_addr(top_v_reg, top_p_reg);
        stk_we    = 1'b0;
        stk_waddr = SAW'(depth_reg - SDW'(1));
        stk_wdata = {top_v_reg, DW'(int'(top_p_reg) + 1)};
        stk_raddr = idx_reg;
        unique case (state_reg)
            S_DISP:    deg_raddr = a_reg[VIW-1:0];
            S_EDGE_RA: deg_raddr = b_reg[VIW-1:0];
            S_EDGE_RB:
            begin
                if (!edge_full)
                begin
                    deg_we = 1'b1;
                    nbr_we = 1'b1;
                end
            end
            S_EDGE_WB:
            begin
                deg_we    = 1'b1;
                nbr_we    = 1'b1;
                deg_waddr = b_reg[VIW-1:0];
                deg_wdata = DW'(int'(deg_b_reg) + 1);
                nbr_waddr = nbr_addr(b_reg[VIW-1:0], deg_b_reg);
                nbr_wdata = a_reg;
            end
            S_CHK:
            begin
                stk_raddr = SAW'(depth_reg - SDW'(2));
                if (!(top_p_reg >= deg_eff) && !skip)
                begin
                    stk_we = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    dfs_ram #(.WIDTH(DW), .DEPTH(NV)) u_deg_ram (
        .clk(clk), .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
        .raddr(deg_raddr), .rdata(deg_rdata)
    );

    dfs_ram #(.WIDTH(VW), .DEPTH(NDEPTH)) u_nbr_ram (
        .clk(clk), .we(nbr_we), .waddr(nbr_waddr), .wdata(nbr_wdata),
        .raddr(nbr_raddr), .rdata(nbr_rdata)
    );

    dfs_ram #(.WIDTH(SEW), .DEPTH(NV)) u_stk_ram (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    always_ff @(posedge clk)
    begin
        dv_reg <= deg_valid_reg[deg_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            vertex_count_reg <= CFG_W'(64);
            deg_valid_reg    <= '0;
            visited_reg      <= '0;
            depth_reg        <= '0;
            out_valid_reg    <= 1'b0;
            cmd_reg          <= CMD_NOP;
            a_reg            <= '0;
            b_reg            <= '0;
            deg_a_reg        <= '0;
            deg_b_reg        <= '0;
            top_v_reg        <= '0;
            top_p_reg        <= '0;
            idx_reg          <= '0;
            res_vertex_reg   <= '0;
            res_status_reg   <= ST_OK;
            vertex_reg       <= '0;
            status_reg       <= ST_OK;
            last_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                vertex_count_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg   <= cmd_t'(cmd);
                        a_reg     <= vertex_a;
                        b_reg     <= vertex_b;
                        state_reg <= S_DISP;
                    end
                end
                S_DISP:
                begin
                    res_vertex_reg <= '0;
                    res_status_reg <= ST_OK;
                    unique case (cmd_reg)
                        CMD_ADD:
                        begin
                            if (a_ok && b_ok)
                            begin
                                state_reg <= S_EDGE_RA;
                            end
                            else
                            begin
                                res_status_reg <= ST_RANGE;
                                state_reg      <= S_ONE;
                            end
                        end
                        CMD_FIND:
                        begin
                            if (a_ok && b_ok)
                            begin
                                visited_reg <= NV'(1) << a_reg[VIW-1:0];
                                top_v_reg   <= a_reg[VIW-1:0];
                                top_p_reg   <= '0;
                                depth_reg   <= SDW'(1);
                                state_reg   <= S_TOP;
                            end
                            else
                            begin
                                res_status_reg <= ST_RANGE;
                                state_reg      <= S_ONE;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            deg_valid_reg <= '0;
                            visited_reg   <= '0;
                            depth_reg     <= '0;
                            state_reg     <= S_ONE;
                        end
                        default:
                        begin
                            state_reg <= S_ONE;
                        end
                    endcase
                end
                S_EDGE_RA:
                begin
                    deg_a_reg <= deg_eff;
                    state_reg <= S_EDGE_RB;
                end
                S_EDGE_RB:
                begin
                    if (edge_full)
                    begin
                        res_status_reg <= ST_FULL;
                        state_reg      <= S_ONE;
                    end
                    else
                    begin
                        deg_valid_reg[a_reg[VIW-1:0]] <= 1'b1;
                        deg_b_reg <= deg_b_eff;
                        state_reg <= S_EDGE_WB;
                    end
                end
                S_EDGE_WB:
                begin
                    deg_valid_reg[b_reg[VIW-1:0]] <= 1'b1;
                    state_reg <= S_ONE;
                end
                S_ONE:
                begin
                    if (out_free)
                    begin
                        vertex_reg    <= res_vertex_reg;
                        status_reg    <= res_status_reg;
                        last_reg      <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_TOP:
                begin
                    if (VW'(top_v_reg) == b_reg)
                    begin
                        state_reg <= S_PATH;
                    end
                    else
                    begin
                        state_reg <= S_CHK;
                    end
                end
                S_CHK:
                begin
                    if (top_p_reg >= deg_eff)
                    begin
                        if (depth_reg == SDW'(1))
                        begin
                            depth_reg      <= '0;
                            res_status_reg <= ST_NOPATH;
                            state_reg      <= S_ONE;
                        end
                        else
                        begin
                            state_reg <= S_POP;
                        end
                    end
                    else if (skip)
                    begin
                        top_p_reg <= DW'(int'(top_p_reg) + 1);
                        state_reg <= S_TOP;
                    end
                    else
                    begin
                        visited_reg[nb[VIW-1:0]] <= 1'b1;
                        top_v_reg <= nb[VIW-1:0];
                        top_p_reg <= '0;
                        depth_reg <= depth_reg + SDW'(1);
                        state_reg <= S_TOP;
                    end
                end
                S_POP:
                begin
                    top_v_reg <= stk_rdata[SEW-1:DW];
                    top_p_reg <= stk_rdata[DW-1:0];
                    depth_reg <= depth_reg - SDW'(1);
                    state_reg <= S_TOP;
                end
                S_PATH:
                begin
                    if (out_free)
                    begin
                        vertex_reg    <= VW'(top_v_reg);
                        status_reg    <= ST_OK;
                        last_reg      <= (depth_reg == SDW'(1));
                        idx_reg       <= SAW'(depth_reg - SDW'(2));
                        if (depth_reg == SDW'(1))
                        begin
                            depth_reg <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_PRD;
                        end
                    end
                end
                S_PRD:
                begin
                    state_reg <= S_PEMIT;
                end
                S_PEMIT:
                begin
                    if (out_free)
                    begin
                        vertex_reg    <= VW'(stk_rdata[SEW-1:DW]);
                        status_reg    <= ST_OK;
                        last_reg      <= (idx_reg == '0);
                        if (idx_reg == '0)
                        begin
                            depth_reg <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg - SAW'(1);
                            state_reg <= S_PRD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign vertex    = vertex_reg;
    assign status    = status_reg;
    assign last      = last_reg;

    `DFS_ASSERT_NEXT(a_busy_after_item, in_valid && !in_stall, state_reg != S_IDLE, "item accepted but sequencer idle")
    `DFS_ASSERT_IMPL(a_depth_bound, 1'b1, depth_reg <= SDW'(NV), "walk stack overflow")
    `DFS_ASSERT_IMPL(a_single_result, out_valid && (status != ST_OK), last && (vertex == '0), "error result not single")
    `DFS_ASSERT_IMPL(a_search_depth, (state_reg == S_TOP) || (state_reg == S_CHK), depth_reg != '0, "search with empty stack")

endmodule

[sv/dfs_ram.sv]
// ----------------------------------------------------------------------------
// dfs generic ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module dfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
